// ----- hdl/b64c_pkg.sv -----
// package: group record, queue request types and alphabet functions of the base64 codec
package b64c_pkg;

    localparam logic [7:0] PAD_CHAR   = 8'h3d;
    localparam logic [7:0] PLUS_CHAR  = 8'h2b;
    localparam logic [7:0] SLASH_CHAR = 8'h2f;

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic        dec;
        logic [23:0] bits;
        logic [2:0]  lim;
        logic        last;
    } grp_t;

    typedef struct packed {
        logic push;
        grp_t grp;
    } q_wr_t;

    typedef struct packed {
        logic valid;
        grp_t grp;
    } q_rd_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26) begin
            return w + 8'd65;
        end else if (v < 6'd52) begin
            return w + 8'd71;
        end else if (v < 6'd62) begin
            return w - 8'd4;
        end else if (v == 6'd62) begin
            return PLUS_CHAR;
        end
        return SLASH_CHAR;
    endfunction

    function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
        logic [7:0] w;
        w = 8'd0;
        if (c >= 8'd48 && c < 8'd58) begin
            w = c + 8'd4;
        end else if (c >= 8'd65 && c < 8'd91) begin
            w = c - 8'd65;
        end else if (c >= 8'd97 && c < 8'd123) begin
            w = c - 8'd71;
        end else if (c == PLUS_CHAR) begin
            w = 8'd62;
        end else if (c == SLASH_CHAR) begin
            w = 8'd63;
        end
        return w[5:0];
    endfunction

    // bytes carried by m non-pad characters: floor(3m/4)
    function automatic logic [2:0] dec_len(input logic [2:0] m);
        case (m)
            3'd2:    return 3'd1;
            3'd3:    return 3'd2;
            3'd4:    return 3'd3;
            default: return 3'd0;
        endcase
    endfunction

endpackage

// ----- hdl/b64c_front.sv -----
// front end: accepts items, gathers groups and pushes finished group records
module b64c_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,   // in_byte
    input  logic            s_tlast,   // in_last
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_data,  // direction
    input  logic            q_full,
    output b64c_pkg::q_wr_t q_wr
);
    import b64c_pkg::*;

    logic        dir_reg, dir_next;
    logic [23:0] bits_reg, bits_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [1:0]  pad_reg, pad_next;

    logic        accept;
    logic [23:0] enc_bits, dec_bits, enc_full, dec_full;
    logic [2:0]  cnt, pads, dec_n;
    logic        enc_done, dec_done, is_pad, done;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        is_pad   = (s_tdata == PAD_CHAR);
        enc_bits = {bits_reg[15:0], s_tdata};
        dec_bits = {bits_reg[17:0], char_to_sextet(s_tdata)};
        cnt      = {1'b0, cnt_reg} + 3'd1;
        pads     = {1'b0, pad_reg} + {2'b00, is_pad};
        enc_done = (cnt == 3'd3) || s_tlast;
        dec_done = (cnt == 3'd4) || s_tlast;
        dec_n    = dec_len(cnt - pads);
        done     = dir_reg ? dec_done : enc_done;

        case (cnt)
            3'd1:    enc_full = {enc_bits[7:0], 16'd0};
            3'd2:    enc_full = {enc_bits[15:0], 8'd0};
            default: enc_full = enc_bits;
        endcase
        case (cnt)
            3'd1:    dec_full = {dec_bits[5:0], 18'd0};
            3'd2:    dec_full = {dec_bits[11:0], 12'd0};
            3'd3:    dec_full = {dec_bits[17:0], 6'd0};
            default: dec_full = dec_bits;
        endcase

        q_wr.grp.dec  = dir_reg;
        q_wr.grp.bits = dir_reg ? dec_full : enc_full;
        q_wr.grp.lim  = dir_reg ? dec_n : cnt + 3'd1;
        q_wr.grp.last = s_tlast;
        q_wr.push     = accept && done && (!dir_reg || dec_n != 3'd0);

        dir_next  = dir_reg;
        bits_next = bits_reg;
        cnt_next  = cnt_reg;
        pad_next  = pad_reg;
        if (cfg_valid && cfg_ready) begin
            dir_next  = cfg_data;
            bits_next = 24'd0;
            cnt_next  = 2'd0;
            pad_next  = 2'd0;
        end else if (accept) begin
            if (done) begin
                bits_next = 24'd0;
                cnt_next  = 2'd0;
                pad_next  = 2'd0;
            end else begin
                bits_next = dir_reg ? dec_bits : enc_bits;
                cnt_next  = cnt[1:0];
                pad_next  = dir_reg ? pads[1:0] : 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dir_reg  <= 1'b0;
            bits_reg <= 24'd0;
            cnt_reg  <= 2'd0;
            pad_reg  <= 2'd0;
        end else begin
            dir_reg  <= dir_next;
            bits_reg <= bits_next;
            cnt_reg  <= cnt_next;
            pad_reg  <= pad_next;
        end
    end

endmodule

// ----- hdl/b64c_queue.sv -----
// short queue of group records between front and back end
module b64c_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  b64c_pkg::q_wr_t q_wr,
    output logic            q_full,
    input  logic            q_pop,
    output b64c_pkg::q_rd_t q_rd
);
    import b64c_pkg::*;

    grp_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, wp_next;
    logic [QAW-1:0] rp_reg, rp_next;
    logic [QAW:0]   cnt_reg, cnt_next;

    always_comb begin
        q_full     = (cnt_reg == (QAW+1)'(QDEPTH));
        q_rd.valid = (cnt_reg != '0);
        q_rd.grp   = mem_reg[rp_reg];

        wp_next  = q_wr.push ? wp_reg + QAW'(1) : wp_reg;
        rp_next  = q_pop ? rp_reg + QAW'(1) : rp_reg;
        cnt_next = cnt_reg;
        if (q_wr.push && !q_pop) begin
            cnt_next = cnt_reg + (QAW+1)'(1);
        end else if (q_pop && !q_wr.push) begin
            cnt_next = cnt_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem_reg[wp_reg] <= q_wr.grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hdl/b64c_back.sv -----
// back end: expands group records into result items, one per cycle unless m_tready stalls the output
module b64c_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  b64c_pkg::q_rd_t q_rd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // out_last
    output logic            busy
);
    import b64c_pkg::*;

    grp_t       cur_reg, cur_next;
    logic [1:0] k_reg, k_next;
    logic       busy_reg, busy_next;
    logic       ov_reg, ov_next;
    logic [7:0] od_reg, od_next;
    logic       ol_reg, ol_next;

    logic       out_free, adv, final_k;
    logic [2:0] nres;
    logic [5:0] sextet;
    logic [7:0] enc_char, dec_byte;

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    assign busy     = busy_reg;

    always_comb begin
        out_free = !ov_reg || m_tready;
        adv      = busy_reg && out_free;
        nres     = cur_reg.dec ? cur_reg.lim : 3'd4;
        final_k  = ({1'b0, k_reg} + 3'd1) == nres;
        q_pop    = q_rd.valid && (!busy_reg || (adv && final_k));

        case (k_reg)
            2'd0:    sextet = cur_reg.bits[23:18];
            2'd1:    sextet = cur_reg.bits[17:12];
            2'd2:    sextet = cur_reg.bits[11:6];
            default: sextet = cur_reg.bits[5:0];
        endcase
        case (k_reg)
            2'd0:    dec_byte = cur_reg.bits[23:16];
            2'd1:    dec_byte = cur_reg.bits[15:8];
            default: dec_byte = cur_reg.bits[7:0];
        endcase
        enc_char = ({1'b0, k_reg} < cur_reg.lim) ? sextet_to_char(sextet) : PAD_CHAR;

        ov_next = ov_reg;
        od_next = od_reg;
        ol_next = ol_reg;
        if (adv) begin
            ov_next = 1'b1;
            od_next = cur_reg.dec ? dec_byte : enc_char;
            ol_next = cur_reg.last && final_k;
        end else if (m_tready) begin
            ov_next = 1'b0;
        end

        cur_next  = cur_reg;
        k_next    = k_reg;
        busy_next = busy_reg;
        if (q_pop) begin
            cur_next  = q_rd.grp;
            k_next    = 2'd0;
            busy_next = 1'b1;
        end else if (adv && final_k) begin
            busy_next = 1'b0;
        end else if (adv) begin
            k_next = k_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        od_reg  <= od_next;
        ol_reg  <= ol_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= 2'd0;
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            k_reg    <= k_next;
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
    end

endmodule

// ----- hdl/base64_codec_top.sv -----
// top level of the streaming base64 codec
// Streaming base64 codec, standard alphabet. cfg_data selects the direction
// (0 encode, 1 decode); a write also drops any partly gathered group. Input
// items are taken one per cycle while the two-entry group queue has room;
// the output register issues one result per cycle unless the receiver holds
// m_tready low. Encoding gives four characters per three bytes. The first
// result of a finished group passes through the queue, the back end's group
// register and then the output register.
module base64_codec_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic       m_tlast,   // out_last
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // direction
);
    import b64c_pkg::*;

    q_wr_t q_wr;
    q_rd_t q_rd;
    logic  q_full;
    logic  q_pop;
    logic  back_busy;

    b64c_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_wr      (q_wr)
    );

    b64c_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rd    (q_rd)
    );

    b64c_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_rd     (q_rd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .busy     (back_busy)
    );

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_wr.push |-> !q_full)
        else $error("group pushed into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_rd.valid)
        else $error("pop from empty queue");

    a_out_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(back_busy))
        else $error("result issued without an active group");

endmodule

// ----- sim/tb_base64_codec_top.sv -----
// testbench for base64_codec_top: directed and random traffic against a predictor
module tb_base64_codec_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b64c_pkg::*;

    localparam int QUIET_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 16;

    localparam logic [7:0] CH_UA = "A";
    localparam logic [7:0] CH_UZ = "Z";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LZ = "z";
    localparam logic [7:0] CH_D0 = "0";
    localparam logic [7:0] CH_D9 = "9";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } codec_out_t;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;   // in_byte
    logic       s_tlast   = 1'b0;    // in_last
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;             // out_byte
    logic       m_tlast;             // out_last
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    codec_out_t  pending_out[$];
    logic        dir_q;
    logic [23:0] grp_bits;
    int          grp_cnt;
    int          pad_cnt;

    int err_count    = 0;
    int quiet_cycles = 0;
    int items_sent   = 0;
    int burst_left   = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;
    int rx_run       = 0;
    int rx_hold      = 0;

    base64_codec_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < 6'd26) begin
            return CH_UA + 8'(v);
        end else if (v < 6'd52) begin
            return CH_LA + 8'(v - 6'd26);
        end else if (v < 6'd62) begin
            return CH_D0 + 8'(v - 6'd52);
        end else if (v == 6'd62) begin
            return PLUS_CHAR;
        end else begin
            return SLASH_CHAR;
        end
    endfunction

    function automatic logic [5:0] char_value(input logic [7:0] c);
        if (c >= CH_UA && c <= CH_UZ) begin
            return 6'(c - CH_UA);
        end else if (c >= CH_LA && c <= CH_LZ) begin
            return 6'(c - CH_LA + 8'd26);
        end else if (c >= CH_D0 && c <= CH_D9) begin
            return 6'(c - CH_D0 + 8'd52);
        end else if (c == PLUS_CHAR) begin
            return 6'd62;
        end else if (c == SLASH_CHAR) begin
            return 6'd63;
        end else begin
            return 6'd0;
        end
    endfunction

    task automatic clear_group();
        grp_bits = '0;
        grp_cnt  = 0;
        pad_cnt  = 0;
    endtask

    task automatic codec_predict(input logic [7:0] b, input logic lst);
        logic [23:0] bits;
        logic [23:0] full;
        int          cnt;
        int          pads;
        int          nres;
        codec_out_t  r;
        if (!dir_q) begin
            bits = {grp_bits[15:0], b};
            cnt  = grp_cnt + 1;
            if (cnt < 3 && !lst) begin
                grp_bits = bits;
                grp_cnt  = cnt;
                return;
            end
            full = bits << (8 * (3 - cnt));
            for (int k = 0; k < 4; k++) begin
                r.data = (k <= cnt) ? sextet_char(6'(full >> (18 - 6 * k))) : PAD_CHAR;
                r.last = lst && (k == 3);
                pending_out.push_back(r);
            end
        end else begin
            bits = {grp_bits[17:0], char_value(b)};
            cnt  = grp_cnt + 1;
            pads = pad_cnt + ((b == PAD_CHAR) ? 1 : 0);
            if (cnt < 4 && !lst) begin
                grp_bits = bits;
                grp_cnt  = cnt;
                pad_cnt  = pads;
                return;
            end
            full = bits << (6 * (4 - cnt));
            nres = ((cnt - pads) * 3) / 4;
            for (int k = 0; k < nres; k++) begin
                r.data = 8'(full >> (16 - 8 * k));
                r.last = lst && (k == nres - 1);
                pending_out.push_back(r);
            end
        end
        clear_group();
    endtask

    task automatic send_item(input logic [7:0] b, input logic lst);
        int gap;
        if (!tx_steady && burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        codec_predict(b, lst);
    endtask

    task automatic send_text(input string txt, input logic lst);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], lst && (i == txt.len() - 1));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_direction(input logic d);
        cfg_valid <= 1'b1;
        cfg_data  <= d;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        dir_q = d;
        clear_group();
    endtask

    task automatic test_encode_directed();
        write_direction(1'b0);
        send_item(8'h00, 1'b1);
        send_item(8'hff, 1'b0);
        send_item(8'hff, 1'b0);
        send_item(8'hff, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        // open group left behind, dropped by the next direction write
        send_item(8'haa, 1'b0);
        wait_idle();
    endtask

    task automatic test_decode_directed();
        write_direction(1'b1);
        send_text("TW", 1'b0);
        wait_idle();
        write_direction(1'b1);
        send_text("TWFu", 1'b1);
        send_text("=A=B", 1'b1);
        send_item("!", 1'b0);
        send_item("~", 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_text("Q", 1'b1);
        send_text("+/z9", 1'b1);
        wait_idle();
    endtask

    task automatic test_encode_random(input int n_items);
        int stop_at;
        int len;
        stop_at = items_sent + n_items;
        write_direction(1'b0);
        while (items_sent < stop_at) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                send_item(8'($urandom_range(0, 255)), i == len - 1);
            end
        end
        wait_idle();
    endtask

    task automatic test_decode_random(input int n_items);
        int stop_at;
        int kind;
        int ngrp;
        int npad;
        int len;
        logic [7:0] ch;
        stop_at = items_sent + n_items;
        write_direction(1'b1);
        while (items_sent < stop_at) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                ngrp = $urandom_range(1, 3);
                npad = $urandom_range(0, 2);
                for (int g = 0; g < ngrp; g++) begin
                    for (int i = 0; i < 4; i++) begin
                        if (g == ngrp - 1 && i >= 4 - npad) begin
                            ch = PAD_CHAR;
                        end else begin
                            ch = sextet_char(6'($urandom_range(0, 63)));
                        end
                        send_item(ch, (g == ngrp - 1) && (i == 3));
                    end
                end
            end else if (kind == 7) begin
                // truncated message
                len = $urandom_range(1, 7);
                for (int i = 0; i < len; i++) begin
                    send_item(sextet_char(6'($urandom_range(0, 63))), i == len - 1);
                end
            end else begin
                len = $urandom_range(1, 9);
                for (int i = 0; i < len; i++) begin
                    ch = ($urandom_range(0, 3) == 0) ? PAD_CHAR : 8'($urandom_range(0, 255));
                    send_item(ch, i == len - 1);
                end
            end
        end
        wait_idle();
    endtask

    always @(posedge aclk) begin
        if (rx_steady) begin
            m_tready <= 1'b1;
        end else if (rx_hold != 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_run != 0) begin
            m_tready <= 1'b1;
            rx_run--;
        end else begin
            rx_run  = $urandom_range(1, 10);
            rx_hold = $urandom_range(1, 4);
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        codec_out_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_out.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result expected none actual data=%h last=%b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = pending_out.pop_front();
                    if (m_tdata !== want.data) begin
                        err_count++;
                        $display("%0t: out_byte mismatch expected %h actual %h",
                                 $time, want.data, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        err_count++;
                        $display("%0t: out_last mismatch expected %b actual %b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: timeout, %0d results outstanding", $time, pending_out.size());
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    initial begin
        dir_q = 1'b0;
        clear_group();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_encode_directed();
        test_decode_directed();
        test_encode_random(55);
        test_decode_random(60);
        test_encode_random(55);
        test_decode_random(60);
        wait_idle();
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/b64c_pkg.sv
hdl/b64c_front.sv
hdl/b64c_queue.sv
hdl/b64c_back.sv
hdl/base64_codec_top.sv
sim/tb_base64_codec_top.sv
